// ===== src/dhc_pkg.sv =====
// Shared types, constants and helpers for the difference-hash compare block.
package dhc_pkg;

  localparam int MAX_DIMENSION = 4096;
  localparam int DIM_W         = 13;  // holds 1..MAX_DIMENSION
  localparam int COUNT_W       = 12;  // pixel position within a row or frame
  localparam int GRAY_W        = 8;
  localparam int HASH_W        = 64;
  localparam int DIST_W        = 7;
  localparam int TOL_W         = 7;

  localparam int SAMPLE_COLS   = 9;
  localparam int SAMPLE_ROWS   = 8;
  localparam int SCOL_W        = 4;   // 0..SAMPLE_COLS
  localparam int BIT_IDX_W     = 3;   // hash bit within a row
  localparam int COL_DIV       = 18;  // column spacing denominator
  localparam int ROW_SHIFT     = 4;   // row spacing denominator is 16
  localparam int SPAN_W        = 17;  // (2x+1)*W and 18*column
  localparam int ROW_PROD_W    = 16;  // (2y+1)*H

  localparam int LUMA_R        = 77;
  localparam int LUMA_G        = 150;
  localparam int LUMA_B        = 29;
  localparam int LUMA_SUM_W    = 16;

  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BASELINE_HASH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BASELINE_PRESENT = 3'd4;

  localparam logic [TOL_W-1:0] TOLERANCE_RESET = 7'd8;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [HASH_W-1:0] hash;
    logic [DIST_W-1:0] distance;
    logic              compared;
    logic              mismatch;
    logic              sticky_fail_out;
  } result_t;

  // Clamp a frame dimension into 1..MAX_DIMENSION.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIMENSION)) begin
      r = DIM_W'(MAX_DIMENSION);
    end
    return r;
  endfunction

endpackage

// ===== src/dhc_sampler.sv =====
// Raster tracking, 9x8 grid sampling and hash accumulation for one frame.
module dhc_sampler
  import dhc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              pixel_valid,
  output logic              pixel_ready,
  input  pixel_t            pixel,
  input  logic [DIM_W-1:0]  frame_width,
  input  logic [DIM_W-1:0]  frame_height,
  output logic              done_valid,
  input  logic              done_ready,
  output logic [HASH_W-1:0] done_hash
);

  // input register
  logic                    pix_valid;
  pixel_t                  pix;

  // frame state
  logic [COUNT_W-1:0]      column_count;
  logic [COUNT_W-1:0]      row_count;
  logic [SCOL_W-1:0]       sample_column;
  logic [GRAY_W-1:0]       previous_gray;
  logic [HASH_W-1:0]       hash_acc;

  logic [LUMA_SUM_W-1:0]   luma_sum;
  logic [GRAY_W-1:0]       gray;
  logic [SPAN_W-1:0]       col_lo;
  logic [SPAN_W-1:0]       col_hi;
  logic [SAMPLE_COLS-1:0]  col_hit;
  logic [SAMPLE_ROWS-1:0]  row_hit;
  logic [SCOL_W-1:0]       sample_column_next;
  logic                    took_sample;
  logic                    diff_set;
  logic [BIT_IDX_W-1:0]    diff_pos;
  logic [7:0]              row_bits;
  logic [HASH_W-1:0]       hash_acc_next;
  logic                    row_end;
  logic                    frame_end;
  logic                    proc_fire;

  assign luma_sum = LUMA_SUM_W'(pix.red)   * LUMA_SUM_W'(LUMA_R)
                  + LUMA_SUM_W'(pix.green) * LUMA_SUM_W'(LUMA_G)
                  + LUMA_SUM_W'(pix.blue)  * LUMA_SUM_W'(LUMA_B);
  assign gray = luma_sum[LUMA_SUM_W-1 -: GRAY_W];

  // current column scaled by 18, so sample x lands here when
  // 18*c <= (2x+1)*W < 18*(c+1)
  assign col_lo = (SPAN_W'(column_count) << 4) + (SPAN_W'(column_count) << 1);
  assign col_hi = col_lo + SPAN_W'(COL_DIV);

  always_comb begin
    for (int x = 0; x < SAMPLE_COLS; x++) begin
      col_hit[x] = (SPAN_W'(SPAN_W'(frame_width) * SPAN_W'(2 * x + 1)) >= col_lo) &&
                   (SPAN_W'(SPAN_W'(frame_width) * SPAN_W'(2 * x + 1)) <  col_hi);
    end
    for (int y = 0; y < SAMPLE_ROWS; y++) begin
      row_hit[y] = ((ROW_PROD_W'(ROW_PROD_W'(frame_height) * ROW_PROD_W'(2 * y + 1))
                     >> ROW_SHIFT) == ROW_PROD_W'(row_count));
    end
  end

  // Every sample column from the current one up to the first miss falls on
  // this pixel; only the first of them can differ from the stored gray.
  always_comb begin
    sample_column_next = SCOL_W'(SAMPLE_COLS);
    for (int x = SAMPLE_COLS - 1; x >= 0; x--) begin
      if ((SCOL_W'(x) >= sample_column) && !col_hit[x]) begin
        sample_column_next = SCOL_W'(x);
      end
    end
  end

  assign took_sample = (sample_column_next != sample_column);
  assign diff_set    = took_sample && (sample_column != '0) && (previous_gray > gray);
  assign diff_pos    = BIT_IDX_W'(sample_column - SCOL_W'(1));
  assign row_bits    = diff_set ? (8'd1 << diff_pos) : 8'd0;

  always_comb begin
    hash_acc_next = hash_acc;
    for (int y = 0; y < SAMPLE_ROWS; y++) begin
      if (row_hit[y]) begin
        hash_acc_next[y*8 +: 8] = hash_acc[y*8 +: 8] | row_bits;
      end
    end
  end

  assign row_end   = (DIM_W'(column_count) + DIM_W'(1)) >= frame_width;
  assign frame_end = row_end && ((DIM_W'(row_count) + DIM_W'(1)) >= frame_height);

  // A frame-ending pixel needs room in the done register; others never wait.
  assign proc_fire   = pix_valid && (!frame_end || !done_valid || done_ready);
  assign pixel_ready = !pix_valid || proc_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (pixel_valid && pixel_ready) begin
      pix_valid <= 1'b1;
    end else if (proc_fire) begin
      pix_valid <= 1'b0;
    end
    if (pixel_valid && pixel_ready) begin
      pix <= pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count  <= '0;
      row_count     <= '0;
      sample_column <= '0;
      previous_gray <= '0;
      hash_acc      <= '0;
    end else if (proc_fire) begin
      if (!row_end) begin
        column_count  <= column_count + COUNT_W'(1);
        sample_column <= sample_column_next;
        previous_gray <= took_sample ? gray : previous_gray;
        hash_acc      <= hash_acc_next;
      end else if (!frame_end) begin
        column_count  <= '0;
        row_count     <= row_count + COUNT_W'(1);
        sample_column <= '0;
        previous_gray <= '0;
        hash_acc      <= hash_acc_next;
      end else begin
        column_count  <= '0;
        row_count     <= '0;
        sample_column <= '0;
        previous_gray <= '0;
        hash_acc      <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done_valid <= 1'b0;
    end else if (proc_fire && frame_end) begin
      done_valid <= 1'b1;
    end else if (done_ready) begin
      done_valid <= 1'b0;
    end
    if (proc_fire && frame_end) begin
      done_hash <= hash_acc_next;
    end
  end

endmodule

// ===== src/dhc_compare.sv =====
// Baseline comparison: Hamming distance, mismatch flag and sticky fail.
module dhc_compare
  import dhc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              hash_valid,
  output logic              hash_ready,
  input  logic [HASH_W-1:0] hash,
  input  logic [HASH_W-1:0] baseline_hash,
  input  logic              baseline_present,
  input  logic [TOL_W-1:0]  tolerance,
  output logic              result_valid,
  input  logic              result_ready,
  output result_t           result
);

  logic                    cnt_valid;
  logic [HASH_W-1:0]       cnt_hash;
  logic [3:0]              byte_count [8];
  logic [3:0]              byte_count_next [8];
  logic [HASH_W-1:0]       diff;
  logic [DIST_W-1:0]       dist_sum;
  logic [DIST_W-1:0]       distance;
  logic                    mismatch;
  logic                    sticky_fail;
  logic                    out_free;

  assign diff = hash ^ baseline_hash;

  // first half: count ones per byte
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      byte_count_next[i] = '0;
      for (int j = 0; j < 8; j++) begin
        byte_count_next[i] = byte_count_next[i] + 4'(diff[i*8 + j]);
      end
    end
  end

  // second half: add the byte counts
  always_comb begin
    dist_sum = '0;
    for (int i = 0; i < 8; i++) begin
      dist_sum = dist_sum + DIST_W'(byte_count[i]);
    end
  end

  // distance never exceeds 64, so comparing against the raw tolerance
  // matches the saturated one
  assign distance = baseline_present ? dist_sum : '0;
  assign mismatch = baseline_present && (dist_sum > tolerance);

  assign out_free   = !result_valid || result_ready;
  assign hash_ready = !cnt_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_valid <= 1'b0;
    end else if (hash_valid && hash_ready) begin
      cnt_valid <= 1'b1;
    end else if (out_free) begin
      cnt_valid <= 1'b0;
    end
    if (hash_valid && hash_ready) begin
      cnt_hash   <= hash;
      byte_count <= byte_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      sticky_fail  <= 1'b0;
    end else begin
      if (cnt_valid && out_free) begin
        result_valid <= 1'b1;
        sticky_fail  <= sticky_fail | mismatch;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
    if (cnt_valid && out_free) begin
      result.hash            <= cnt_hash;
      result.distance        <= distance;
      result.compared        <= baseline_present;
      result.mismatch        <= mismatch;
      result.sticky_fail_out <= sticky_fail | mismatch;
    end
  end

endmodule

// ===== src/image_dhash_compare.sv =====
// Top level: 64-bit difference hash of a streamed RGB frame with baseline compare.
//
//   channel  | dir | handshake               | payload
//   ---------+-----+-------------------------+---------------------------------
//   pixel    | in  | pixel_valid/pixel_ready | pixel_t: red, green, blue
//   result   | out | result_valid/ready      | result_t: hash, distance, flags
//   cfg      | in  | cfg_valid/cfg_ready     | cfg_index, cfg_data
//
// One pixel beat is taken every cycle unless a frame end stalls the input (see
// below); the frame state updates behind the pixel input register, so the
// sustained rate is one pixel per clock. After the frame's last pixel beat a
// result passes the pixel register, hash register, per-byte count stage, result register.
// Reset clears the frame position, hash, sticky fail and config to defaults.
// Only a stalled result backs up the count stage and hash register; pixels keep
// flowing until a frame-ending pixel finds the hash register still occupied.
module image_dhash_compare
  import dhc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pixel_valid,
  output logic                  pixel_ready,
  input  pixel_t                pixel,
  output logic                  result_valid,
  input  logic                  result_ready,
  output result_t               result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration registers; dimensions are stored already clamped
  logic [DIM_W-1:0]  frame_width;
  logic [DIM_W-1:0]  frame_height;
  logic [TOL_W-1:0]  tolerance;
  logic [HASH_W-1:0] baseline_hash;
  logic              baseline_present;

  // sampler to compare hand-off
  logic              done_valid;
  logic              done_ready;
  logic [HASH_W-1:0] done_hash;

  // register writes are always accepted
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width      <= DIM_W'(1);
      frame_height     <= DIM_W'(1);
      tolerance        <= TOLERANCE_RESET;
      baseline_hash    <= '0;
      baseline_present <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH: begin
          frame_width <= clamp_dim(cfg_data[DIM_W-1:0]);
        end
        CFG_FRAME_HEIGHT: begin
          frame_height <= clamp_dim(cfg_data[DIM_W-1:0]);
        end
        CFG_TOLERANCE: begin
          tolerance <= cfg_data[TOL_W-1:0];
        end
        CFG_BASELINE_HASH: begin
          baseline_hash <= cfg_data[HASH_W-1:0];
        end
        CFG_BASELINE_PRESENT: begin
          baseline_present <= cfg_data[0];
        end
        default: begin
          // drop writes to unmapped indexes
        end
      endcase
    end
  end

  // track raster position, pick grid samples, build the hash
  dhc_sampler u_sampler (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .pixel        (pixel),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .done_valid   (done_valid),
    .done_ready   (done_ready),
    .done_hash    (done_hash)
  );

  // compare each finished hash with the baseline and hold the result beat
  dhc_compare u_compare (
    .clk              (clk),
    .rst              (rst),
    .hash_valid       (done_valid),
    .hash_ready       (done_ready),
    .hash             (done_hash),
    .baseline_hash    (baseline_hash),
    .baseline_present (baseline_present),
    .tolerance        (tolerance),
    .result_valid     (result_valid),
    .result_ready     (result_ready),
    .result           (result)
  );

endmodule
